FILE: src/lsm_pkg.sv
// ----------------------------------------------------------------------------
// Line substring matcher package
// Shared types, codes and helpers for the line matcher blocks.
// ----------------------------------------------------------------------------
package lsm_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PatBytes = 16;
  localparam int unsigned PatIdxW  = 4;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [ByteW-1:0] NEWLINE = 8'd10;
  localparam logic [ByteW-1:0] UPPER_A = 8'd65;
  localparam logic [ByteW-1:0] UPPER_Z = 8'd90;
  localparam logic [ByteW-1:0] CASE_OFFSET = 8'd32;

  typedef enum logic [1:0] {
    KIND_LINE      = 2'd0,
    KIND_TOTAL     = 2'd1,
    KIND_NOT_FOUND = 2'd2
  } kind_e;

  typedef enum logic {
    ACT_TEXT = 1'b0,
    ACT_EOF  = 1'b1
  } action_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_PAT_LOW    = 3'd0,
    CFG_PAT_HIGH   = 3'd1,
    CFG_PAT_LEN    = 3'd2,
    CFG_CASE_FOLD  = 3'd3,
    CFG_COUNT_MODE = 3'd4
  } cfg_addr_e;

  typedef struct packed {
    logic [PatBytes*ByteW-1:0] pattern;     // byte 0 in bits 7:0
    logic [LenW-1:0]           pat_len;
    logic                      case_fold;
    logic                      count_mode;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [CountW-1:0] line_index;
    logic [CountW-1:0] total;
    logic              last;
  } result_t;

  // Lower-case ASCII A-Z when folding is on
  function automatic logic [ByteW-1:0] fold(input logic [ByteW-1:0] c, input logic en);
    if (en && c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == '1) ? v : v + CountW'(1);
  endfunction

endpackage

FILE: src/line_substring_matcher_unit.sv
// ----------------------------------------------------------------------------
// Line substring matcher
// Fixed-string search over newline-separated lines of a byte stream.
// ----------------------------------------------------------------------------
// Text enters on the s_axis channel, one byte per transaction; tuser high
// marks end of file (tdata is then ignored). Reports leave on m_axis: tuser
// is the report kind (matching line, total count, not found), tdata holds
// the line number and the running match total, tlast marks the last report
// caused by one input transaction (each input causes at most one report).
// The config channel writes pattern bytes, length, case folding and count
// mode; write it only while the stream is idle.
// Each byte is handled as it is accepted: the window compare runs in parallel
// between the state registers and the output register, so a report is
// registered in the output register (or in the skid entry while m_axis stalls)
// and the block takes one byte every cycle while s_axis_tready_o is high.
// A result register plus one skid entry buffer reports; s_axis_tready_o
// drops only when both hold a report, i.e. after the receiver has stalled
// with a further report pending.
// Reset clears line and match state, the window fill count and all config registers. End
// of file returns the stream state to reset values; config is kept.
// ----------------------------------------------------------------------------
module line_substring_matcher_unit #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] data_byte
  input  logic                          s_axis_tuser_i,   // [0] action
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [63:0]                   m_axis_tdata_o,   // [31:0] line_index, [63:32] total_matches
  output logic [1:0]                    m_axis_tuser_o,   // [1:0] report_kind
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsm_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [lsm_pkg::CfgDataW-1:0]  cfg_data_i
);

  lsm_pkg::cfg_t    cfg;
  lsm_pkg::result_t res;
  logic             res_valid;
  logic             space;
  logic             in_acc, is_eof, is_nl, is_push;
  logic             win_hit, empty_pat, line_hit, do_end;
  logic             line_open_q, line_open_d;
  logic             lhm_q, lhm_d;
  logic [lsm_pkg::CountW-1:0] line_cnt_q, line_cnt_d, line_cnt_inc;
  logic [lsm_pkg::CountW-1:0] match_q, match_d, match_inc, match_after;

  lsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign s_axis_tready_o = space;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_eof  = in_acc && (lsm_pkg::action_e'(s_axis_tuser_i) == lsm_pkg::ACT_EOF);
  assign is_nl   = in_acc && (lsm_pkg::action_e'(s_axis_tuser_i) == lsm_pkg::ACT_TEXT) &&
                   (s_axis_tdata_i == lsm_pkg::NEWLINE);
  assign is_push = in_acc && (lsm_pkg::action_e'(s_axis_tuser_i) == lsm_pkg::ACT_TEXT) &&
                   (s_axis_tdata_i != lsm_pkg::NEWLINE);

  lsm_window #(
    .PatternMax (PATTERN_MAX)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (is_push),
    .clear_i     (is_nl || is_eof),
    .byte_i      (s_axis_tdata_i),
    .hit_o       (win_hit),
    .empty_pat_o (empty_pat)
  );

  assign line_hit     = lhm_q || empty_pat;
  assign line_cnt_inc = lsm_pkg::sat_inc(line_cnt_q);
  assign match_inc    = line_hit ? lsm_pkg::sat_inc(match_q) : match_q;
  assign do_end       = is_nl || (is_eof && line_open_q);
  assign match_after  = do_end ? match_inc : match_q;

  // Report for this transaction
  always_comb begin
    res_valid      = 1'b0;
    res.kind       = lsm_pkg::KIND_LINE;
    res.line_index = line_cnt_inc;
    res.total      = match_inc;
    res.last       = 1'b1;
    if (is_nl) begin
      res_valid = line_hit && !cfg.count_mode;
    end else if (is_eof) begin
      if (cfg.count_mode) begin
        res_valid      = 1'b1;
        res.kind       = lsm_pkg::KIND_TOTAL;
        res.line_index = '0;
        res.total      = match_after;
      end else if (match_after == '0) begin
        res_valid      = 1'b1;
        res.kind       = lsm_pkg::KIND_NOT_FOUND;
        res.line_index = '0;
        res.total      = '0;
      end else begin
        // unterminated last line that matched
        res_valid = line_open_q && line_hit;
      end
    end
  end

  always_comb begin
    line_open_d = line_open_q;
    lhm_d       = lhm_q;
    line_cnt_d  = line_cnt_q;
    match_d     = match_q;
    if (is_push) begin
      line_open_d = 1'b1;
      if (win_hit) begin
        lhm_d = 1'b1;
      end
    end else if (is_nl) begin
      line_open_d = 1'b0;
      lhm_d       = 1'b0;
      line_cnt_d  = line_cnt_inc;
      match_d     = match_inc;
    end else if (is_eof) begin
      line_open_d = 1'b0;
      lhm_d       = 1'b0;
      line_cnt_d  = '0;
      match_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_open_q <= 1'b0;
      lhm_q       <= 1'b0;
      line_cnt_q  <= '0;
      match_q     <= '0;
    end else begin
      line_open_q <= line_open_d;
      lhm_q       <= lhm_d;
      line_cnt_q  <= line_cnt_d;
      match_q     <= match_d;
    end
  end

  lsm_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (res_valid),
    .res_i           (res),
    .space_o         (space),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  a_block_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input blocked with no report pending");

  a_match_le_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q <= line_cnt_q)
    else $error("match count exceeds line count");

  a_line_report_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == lsm_pkg::KIND_LINE) |->
      (m_axis_tdata_o[31:0] != '0 && m_axis_tdata_o[63:32] != '0))
    else $error("line report with zero line number or total");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_eof |=> (line_cnt_q == '0 && match_q == '0 && !line_open_q))
    else $error("stream state not cleared after end of file");
`endif

endmodule

FILE: src/lsm_cfg.sv
// ----------------------------------------------------------------------------
// Line matcher configuration registers
// Holds pattern, length and mode bits written over the config channel.
// ----------------------------------------------------------------------------
module lsm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsm_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [lsm_pkg::CfgDataW-1:0]  cfg_data_i,
  output lsm_pkg::cfg_t                 cfg_o
);

  lsm_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (lsm_pkg::cfg_addr_e'(cfg_addr_i))
        lsm_pkg::CFG_PAT_LOW:    cfg_d.pattern[63:0]   = cfg_data_i;
        lsm_pkg::CFG_PAT_HIGH:   cfg_d.pattern[127:64] = cfg_data_i;
        lsm_pkg::CFG_PAT_LEN:    cfg_d.pat_len = cfg_data_i[lsm_pkg::LenW-1:0];
        lsm_pkg::CFG_CASE_FOLD:  cfg_d.case_fold = cfg_data_i[0];
        lsm_pkg::CFG_COUNT_MODE: cfg_d.count_mode = cfg_data_i[0];
        default: ;  // unmapped index: drop the transaction
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/lsm_window.sv
// ----------------------------------------------------------------------------
// Line matcher window
// Shift register of recent line bytes and parallel compare against pattern.
// ----------------------------------------------------------------------------
module lsm_window #(
  parameter int unsigned PatternMax = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lsm_pkg::cfg_t             cfg_i,
  input  logic                      push_i,
  input  logic                      clear_i,
  input  logic [lsm_pkg::ByteW-1:0] byte_i,
  output logic                      hit_o,
  output logic                      empty_pat_o
);

  localparam int unsigned CntW = $clog2(PatternMax + 1);

  logic [lsm_pkg::ByteW-1:0] win_q [PatternMax];
  logic [lsm_pkg::ByteW-1:0] win_d [PatternMax];
  logic [lsm_pkg::ByteW-1:0] pat   [lsm_pkg::PatBytes];
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [lsm_pkg::LenW-1:0]  used_len;
  logic [PatternMax-1:0]     pos_ok;

  assign used_len = (cfg_i.pat_len > lsm_pkg::LenW'(PatternMax)) ?
                    lsm_pkg::LenW'(PatternMax) : cfg_i.pat_len;
  assign empty_pat_o = (used_len == '0);

  always_comb begin
    for (int i = 0; i < lsm_pkg::PatBytes; i++) begin
      pat[i] = cfg_i.pattern[i*lsm_pkg::ByteW +: lsm_pkg::ByteW];
    end
  end

  // Window after this byte: newest at position 0
  always_comb begin
    win_d[0] = byte_i;
    for (int k = 1; k < PatternMax; k++) begin
      win_d[k] = win_q[k-1];
    end
    cnt_d = (cnt_q == CntW'(PatternMax)) ? cnt_q : cnt_q + CntW'(1);
  end

  // Position j pairs with pattern byte used_len-1-j
  always_comb begin
    logic [lsm_pkg::LenW-1:0] p;
    for (int j = 0; j < PatternMax; j++) begin
      p = used_len - lsm_pkg::LenW'(1) - lsm_pkg::LenW'(j);
      pos_ok[j] = (lsm_pkg::LenW'(j) >= used_len) ||
                  (lsm_pkg::fold(win_d[j], cfg_i.case_fold) ==
                   lsm_pkg::fold(pat[p[lsm_pkg::PatIdxW-1:0]], cfg_i.case_fold));
    end
  end

  assign hit_o = (&pos_ok) && (lsm_pkg::LenW'(cnt_d) >= used_len);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (clear_i) begin
      cnt_q <= '0;
    end else if (push_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: src/lsm_out.sv
// ----------------------------------------------------------------------------
// Line matcher output stage
// Result register with a skid entry so input keeps flowing during a stall until the skid entry is full.
// ----------------------------------------------------------------------------
module lsm_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  lsm_pkg::result_t            res_i,
  output logic                        space_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [2*lsm_pkg::CountW-1:0] m_axis_tdata_o,
  output logic [1:0]                  m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);

  lsm_pkg::result_t out_q, skid_q;
  logic             out_valid_q, skid_valid_q;
  logic             pop;

  assign pop     = out_valid_q && m_axis_tready_i;
  assign space_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || pop) begin
      if (push_i) begin
        out_q <= res_i;
      end
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.total, out_q.line_index};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;

endmodule
